// ----- design/ffba_pkg.sv -----
// Shared constants, codes and widths for the first-fit block allocator.
// No dependencies; every other design file refers to it by scoped names.
package ffba_pkg;

    // payload field widths (fixed by the item format)
    localparam int OP_W     = 2;
    localparam int SEL_W    = 4;
    localparam int REQ_W    = 16;
    localparam int STATUS_W = 2;
    localparam int BLK_W    = 4;
    localparam int REM_W    = 16;
    localparam int CFG_W    = 5;

    // default geometry
    localparam int NUM_BLOCKS_DEF = 16;
    localparam int SIZE_WIDTH_DEF = 16;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;

    // operation codes
    localparam t_op OP_LOAD  = 2'd0;
    localparam t_op OP_ALLOC = 2'd1;
    localparam t_op OP_READ  = 2'd2;

    // result status codes
    localparam t_status STATUS_OK     = 2'd0;
    localparam t_status STATUS_NOFIT  = 2'd1;
    localparam t_status STATUS_BADIDX = 2'd2;

    localparam logic [CFG_W-1:0] BLOCK_COUNT_RESET = 5'd16;

endpackage

// ----- design/ffba_if.sv -----
// Valid/ready channel interfaces for allocator request and result items.
// Depends on ffba_pkg for the payload widths.
interface ffba_in_if;
    logic                           valid;
    logic                           ready;
    logic [ffba_pkg::OP_W-1:0]      operation;
    logic [ffba_pkg::SEL_W-1:0]     block_select;
    logic [ffba_pkg::REQ_W-1:0]     size_value;

    modport source (output valid, output operation, output block_select,
                    output size_value, input ready);
    modport sink   (input valid, input operation, input block_select,
                    input size_value, output ready);
endinterface

interface ffba_out_if;
    logic                           valid;
    logic                           ready;
    logic [ffba_pkg::STATUS_W-1:0]  status;
    logic [ffba_pkg::BLK_W-1:0]     granted_block;
    logic [ffba_pkg::REM_W-1:0]     remaining_size;

    modport source (output valid, output status, output granted_block,
                    output remaining_size, input ready);
    modport sink   (input valid, input status, input granted_block,
                    input remaining_size, output ready);
endinterface

// ----- design/first_fit_block_allocator_core.sv -----
// Top level of the first-fit block allocator: sequencer, config register,
// output register. Depends on ffba_pkg, ffba_if, ffba_ram, ffba_fit_unit.
//
//   channel   dir  signals                                           handshake
//   i_in      in   operation, block_select, size_value               valid/ready
//   o_out     out  status, granted_block, remaining_size             valid/ready
//   i_cfg     in   i_cfg_we, i_cfg_data (block_count)                write strobe
//
// Sequence: a load, a bad index, an unknown operation or an allocate with no
// blocks in use goes from EXEC straight to EMIT; a read passes through RDWAIT;
// an allocate scans the table in SCAN from entry 0 up to the first fit, or up
// to the block count in effect (clamped to NUM_BLOCKS) when nothing fits. In
// the scan the table RAM gives one entry per cycle to the single fit unit.
// Reset clears the sequencer, the output valid and sets block_count to 16; the
// block table is not cleared and holds garbage until each entry is loaded.
// The input is taken only while the sequencer is idle; a result waiting in the
// output register does not block the next accept, only the next result.
module first_fit_block_allocator_core #(
    parameter int NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_WIDTH = ffba_pkg::SIZE_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ffba_pkg::CFG_W-1:0]  i_cfg_data,
    ffba_in_if.sink                     i_in,
    ffba_out_if.source                  o_out
);

    // table address, block counter, and a width wide enough for both
    // the counter and the 4-bit block select
    localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam int XW = (CW > ffba_pkg::SEL_W) ? CW : ffba_pkg::SEL_W;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_RDWAIT = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    // control state
    logic [2:0]                    r_state,       n_state;
    logic [ffba_pkg::CFG_W-1:0]    r_block_count, n_block_count;
    logic                          r_out_valid,   n_out_valid;

    // item and result payload
    ffba_pkg::t_op                 r_op,          n_op;
    logic [ffba_pkg::SEL_W-1:0]    r_sel,         n_sel;
    logic [SIZE_WIDTH-1:0]         r_size,        n_size;
    logic [CW-1:0]                 r_idx,         n_idx;
    ffba_pkg::t_status             r_res_status,  n_res_status;
    logic [ffba_pkg::BLK_W-1:0]    r_res_block,   n_res_block;
    logic [ffba_pkg::REM_W-1:0]    r_res_rem,     n_res_rem;
    ffba_pkg::t_status             r_out_status,  n_out_status;
    logic [ffba_pkg::BLK_W-1:0]    r_out_block,   n_out_block;
    logic [ffba_pkg::REM_W-1:0]    r_out_rem,     n_out_rem;

    // table RAM port
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [SIZE_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [SIZE_WIDTH-1:0] ram_rdata;

    // fit unit
    logic                  fit;
    logic [SIZE_WIDTH-1:0] fit_remain;

    logic [CW-1:0] active;      // block_count clamped to the table depth
    logic          sel_ok;
    logic [CW-1:0] idx_next;

    ffba_ram #(
        .WIDTH (SIZE_WIDTH),
        .DEPTH (NUM_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // entry on the read port against the latched request
    ffba_fit_unit #(
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_fit (
        .i_entry   (ram_rdata),
        .i_request (r_size),
        .o_fit     (fit),
        .o_remain  (fit_remain)
    );

    always_comb begin
        if (32'(r_block_count) > NUM_BLOCKS) begin
            active = CW'(NUM_BLOCKS);
        end else begin
            active = CW'(r_block_count);
        end
    end

    assign sel_ok   = XW'(r_sel) < XW'(active);
    assign idx_next = r_idx + CW'(1);

    always_comb begin
        n_state       = r_state;
        n_block_count = r_block_count;
        n_out_valid   = r_out_valid;
        n_op          = r_op;
        n_sel         = r_sel;
        n_size        = r_size;
        n_idx         = r_idx;
        n_res_status  = r_res_status;
        n_res_block   = r_res_block;
        n_res_rem     = r_res_rem;
        n_out_status  = r_out_status;
        n_out_block   = r_out_block;
        n_out_rem     = r_out_rem;

        ram_we    = 1'b0;
        ram_waddr = AW'(r_sel);
        ram_wdata = r_size;
        ram_re    = 1'b0;
        ram_raddr = AW'(r_sel);

        if (i_cfg_we) begin
            n_block_count = i_cfg_data;
        end

        // result taken downstream
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op    = i_in.operation;
                    n_sel   = i_in.block_select;
                    n_size  = SIZE_WIDTH'(i_in.size_value);
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                // default: bad index or unknown operation
                n_res_status = ffba_pkg::STATUS_BADIDX;
                n_res_block  = '0;
                n_res_rem    = '0;
                n_state      = S_EMIT;
                case (r_op)
                    ffba_pkg::OP_LOAD: begin
                        if (sel_ok) begin
                            ram_we       = 1'b1;
                            n_res_status = ffba_pkg::STATUS_OK;
                            n_res_rem    = ffba_pkg::REM_W'(r_size);
                        end
                    end
                    ffba_pkg::OP_READ: begin
                        if (sel_ok) begin
                            ram_re  = 1'b1;
                            n_state = S_RDWAIT;
                        end
                    end
                    ffba_pkg::OP_ALLOC: begin
                        if (active == '0) begin
                            n_res_status = ffba_pkg::STATUS_NOFIT;
                        end else begin
                            // prime the scan with entry 0
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                            n_idx     = '0;
                            n_state   = S_SCAN;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            S_RDWAIT: begin
                n_res_status = ffba_pkg::STATUS_OK;
                n_res_block  = '0;
                n_res_rem    = ffba_pkg::REM_W'(ram_rdata);
                n_state      = S_EMIT;
            end

            S_SCAN: begin
                // ram_rdata holds entry r_idx; on a miss fetch r_idx+1
                if (fit) begin
                    ram_we       = 1'b1;
                    ram_waddr    = r_idx[AW-1:0];
                    ram_wdata    = fit_remain;
                    n_res_status = ffba_pkg::STATUS_OK;
                    n_res_block  = ffba_pkg::BLK_W'(r_idx);
                    n_res_rem    = ffba_pkg::REM_W'(fit_remain);
                    n_state      = S_EMIT;
                end else if (idx_next == active) begin
                    n_res_status = ffba_pkg::STATUS_NOFIT;
                    n_res_block  = '0;
                    n_res_rem    = '0;
                    n_state      = S_EMIT;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_next[AW-1:0];
                    n_idx     = idx_next;
                end
            end

            S_EMIT: begin
                // wait for a free output register
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_block  = r_res_block;
                    n_out_rem    = r_res_rem;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_block_count <= ffba_pkg::BLOCK_COUNT_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_block_count <= n_block_count;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_sel        <= n_sel;
        r_size       <= n_size;
        r_idx        <= n_idx;
        r_res_status <= n_res_status;
        r_res_block  <= n_res_block;
        r_res_rem    <= n_res_rem;
        r_out_status <= n_out_status;
        r_out_block  <= n_out_block;
        r_out_rem    <= n_out_rem;
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_status;
    assign o_out.granted_block  = r_out_block;
    assign o_out.remaining_size = r_out_rem;

endmodule

// ----- design/ffba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on ffba_pkg for default sizes only; contents are undefined until written.
module ffba_ram #(
    parameter int WIDTH = ffba_pkg::SIZE_WIDTH_DEF,
    parameter int DEPTH = ffba_pkg::NUM_BLOCKS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/ffba_fit_unit.sv -----
// Shared fit unit: compares one table entry against the request and forms
// the remainder. Depends on ffba_pkg for the default width only.
module ffba_fit_unit #(
    parameter int SIZE_WIDTH = ffba_pkg::SIZE_WIDTH_DEF
) (
    input  logic [SIZE_WIDTH-1:0] i_entry,
    input  logic [SIZE_WIDTH-1:0] i_request,
    output logic                  o_fit,
    output logic [SIZE_WIDTH-1:0] o_remain
);

    logic [SIZE_WIDTH:0] diff;

    // one subtractor does both jobs: borrow out means no fit
    assign diff     = {1'b0, i_entry} - {1'b0, i_request};
    assign o_fit    = ~diff[SIZE_WIDTH];
    assign o_remain = diff[SIZE_WIDTH-1:0];

endmodule

// ----- design/ffba_chk.sv -----
// Port-level checker for the first-fit block allocator, bound to the top.
// Depends on ffba_pkg and first_fit_block_allocator_core.
module ffba_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [ffba_pkg::STATUS_W-1:0]  i_out_status,
    input logic [ffba_pkg::BLK_W-1:0]     i_out_block,
    input logic [ffba_pkg::REM_W-1:0]     i_out_rem
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again while an item is in work");

    // failure results carry no block and no size
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != ffba_pkg::STATUS_OK)
        |-> (i_out_block == '0) && (i_out_rem == '0))
        else $error("failed result with nonzero block or size");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_status == ffba_pkg::STATUS_OK)
                     || (i_out_status == ffba_pkg::STATUS_NOFIT)
                     || (i_out_status == ffba_pkg::STATUS_BADIDX))
        else $error("undefined status code");

endmodule

bind first_fit_block_allocator_core ffba_chk u_ffba_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_block  (o_out.granted_block),
    .i_out_rem    (o_out.remaining_size)
);
